// File: rtl/tfd_pkg.sv
package tfd_pkg;

    localparam int MAX_RAW_BYTES    = 4096;
    localparam int MAX_TOKENS       = 1024;
    localparam int COUNT_TEXT_LIMIT = 32;
    localparam int MAX_RESULTS      = 3;

    localparam int RAW_CAP_W   = 13;
    localparam int TOKEN_CAP_W = 11;
    localparam int CFG_DATA_W  = RAW_CAP_W;
    localparam int DIGITS_W    = 6;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [RAW_CAP_W-1:0]   RAW_CAP_RESET   = 13'd256;
    localparam logic [TOKEN_CAP_W-1:0] TOKEN_CAP_RESET = 11'd64;

    localparam logic [1:0] KIND_RAW   = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_SMALL  = 2'd2;

    localparam logic CFG_RAW_CAP   = 1'b0;
    localparam logic CFG_TOKEN_CAP = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [31:0]      value;
        logic [1:0]              status;
        logic                    frame_mode;
        logic [TOKEN_CAP_W-1:0]  token_total;
        logic                    run_last;
    } tfd_result_t;

    typedef struct packed {
        logic [1:0]                      count;
        tfd_result_t [MAX_RESULTS-1:0]   slot;
    } tfd_push_t;

endpackage

// File: rtl/tfd_if.sv
interface tfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               frame_mode;
    logic [10:0]        token_total;
    logic               run_last;

    modport source (output valid, output kind, output value, output status,
                    output frame_mode, output token_total, output run_last, input ready);
    modport sink   (input valid, input kind, input value, input status,
                    input frame_mode, input token_total, input run_last, output ready);
endinterface

// File: rtl/tfd_parse.sv
module tfd_parse
    import tfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    tfd_in_if.sink                 frame,
    input  logic [RAW_CAP_W-1:0]   raw_cap,
    input  logic [TOKEN_CAP_W-1:0] token_cap,
    input  logic                   space_ok,
    output tfd_push_t              push
);

    typedef enum logic [2:0] {PH_PREFIX, PH_RAW, PH_COUNT, PH_IDS, PH_SKIP} phase_t;

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic                   fire;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             prefix_pos_reg, prefix_pos_next;
    logic                   prefix_kind_reg, prefix_kind_next;
    logic                   newline_held_reg, newline_held_next;
    logic [RAW_CAP_W-1:0]   payload_length_reg, payload_length_next;
    logic [TOKEN_CAP_W-1:0] count_value_reg, count_value_next;
    logic [DIGITS_W-1:0]    count_digits_reg, count_digits_next;
    logic                   count_neg_reg, count_neg_next;
    logic                   count_has_digit_reg, count_has_digit_next;
    logic                   count_bad_reg, count_bad_next;
    logic [31:0]            id_acc_reg, id_acc_next;
    logic                   id_negative_reg, id_negative_next;
    logic                   id_has_digit_reg, id_has_digit_next;
    logic                   id_started_reg, id_started_next;
    logic [TOKEN_CAP_W-1:0] ids_done_reg, ids_done_next;
    logic [1:0]             first_error_reg, first_error_next;

    function automatic logic [7:0] prefix_char(input logic kind, input logic [1:0] pos);
        logic [7:0] c;
        unique case ({kind, pos})
            3'b001:  c = 8'h41;
            3'b010:  c = 8'h57;
            3'b101:  c = 8'h4F;
            3'b110:  c = 8'h4B;
            3'b011,
            3'b111:  c = CH_PIPE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic tfd_result_t make_result(input logic [1:0] kind,
                                                input logic [31:0] value,
                                                input logic [1:0] status,
                                                input logic mode,
                                                input logic [TOKEN_CAP_W-1:0] total);
        tfd_result_t r;
        r.kind        = kind;
        r.value       = value;
        r.status      = status;
        r.frame_mode  = mode;
        r.token_total = total;
        r.run_last    = 1'b0;
        return r;
    endfunction

    function automatic logic [RAW_CAP_W-1:0] len_inc(input logic [RAW_CAP_W-1:0] len);
        return (len < RAW_CAP_W'(MAX_RAW_BYTES)) ? len + 1'b1 : len;
    endfunction

    assign fire        = in_valid_reg && space_ok;
    assign frame.ready = !in_valid_reg || fire;

    always_comb
    begin
        logic [7:0]             b;
        logic                   is_digit;
        logic [3:0]             d;
        logic                   tail_nl;
        logic                   skip;
        logic [1:0]             n;
        logic [14:0]            cv_wide;
        logic [35:0]            id_wide;
        logic [35:0]            id_lim;
        logic [TOKEN_CAP_W:0]   ids_plus;
        logic [RAW_CAP_W:0]     len_plus;
        logic [1:0]             st;
        logic                   mode;
        logic [TOKEN_CAP_W-1:0] total;

        b        = byte_reg;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        d        = 4'(b - CH_ZERO);
        tail_nl  = 1'b0;
        skip     = 1'b0;
        n        = 2'd0;
        cv_wide  = '0;
        id_wide  = '0;
        id_lim   = '0;
        ids_plus = {1'b0, ids_done_reg} + 1'b1;
        len_plus = '0;
        st       = ST_OK;
        mode     = 1'b0;
        total    = '0;

        push.count = 2'd0;
        push.slot  = '0;

        phase_next           = phase_reg;
        prefix_pos_next      = prefix_pos_reg;
        prefix_kind_next     = prefix_kind_reg;
        newline_held_next    = newline_held_reg;
        payload_length_next  = payload_length_reg;
        count_value_next     = count_value_reg;
        count_digits_next    = count_digits_reg;
        count_neg_next       = count_neg_reg;
        count_has_digit_next = count_has_digit_reg;
        count_bad_next       = count_bad_reg;
        id_acc_next          = id_acc_reg;
        id_negative_next     = id_negative_reg;
        id_has_digit_next    = id_has_digit_reg;
        id_started_next      = id_started_reg;
        ids_done_next        = ids_done_reg;
        first_error_next     = first_error_reg;

        unique case (phase_reg)
            PH_PREFIX:
            begin
                if (prefix_pos_reg == 2'd0)
                begin
                    if (b == 8'h52)
                        prefix_kind_next = 1'b0;
                    else if (b == 8'h54)
                        prefix_kind_next = 1'b1;
                    else
                        skip = 1'b1;
                end
                else if (b != prefix_char(prefix_kind_reg, prefix_pos_reg))
                begin
                    skip = 1'b1;
                end
                if (skip)
                    phase_next = PH_SKIP;
                else
                begin
                    prefix_pos_next = prefix_pos_reg + 1'b1;
                    if (prefix_pos_reg == 2'd3)
                        phase_next = prefix_kind_next ? PH_COUNT : PH_RAW;
                end
            end
            PH_RAW:
            begin
                if (newline_held_reg)
                begin
                    push.slot[n] = make_result(KIND_RAW, {24'd0, CH_NEWLINE}, ST_OK, 1'b0, '0);
                    n = n + 1'b1;
                    payload_length_next = len_inc(payload_length_next);
                    newline_held_next = 1'b0;
                end
                if (b == CH_NEWLINE)
                begin
                    if (!last_reg)
                        newline_held_next = 1'b1;
                end
                else
                begin
                    push.slot[n] = make_result(KIND_RAW, {24'd0, b}, ST_OK, 1'b0, '0);
                    n = n + 1'b1;
                    payload_length_next = len_inc(payload_length_next);
                end
            end
            PH_COUNT,
            PH_IDS:
            begin
                if (last_reg && b == CH_NEWLINE)
                begin
                    tail_nl = 1'b1;
                    if (phase_reg == PH_COUNT)
                        first_error_next = ST_FORMAT;
                    else if (first_error_reg == ST_OK)
                    begin
                        if (count_value_reg == '0)
                        begin
                            if (id_started_reg)
                                first_error_next = ST_FORMAT;
                        end
                        else if (id_has_digit_reg && ids_plus == {1'b0, count_value_reg})
                        begin
                            push.slot[n] = make_result(KIND_TOKEN,
                                id_negative_reg ? 32'd0 - id_acc_reg : id_acc_reg,
                                ST_OK, 1'b0, '0);
                            n = n + 1'b1;
                            ids_done_next = ids_plus[TOKEN_CAP_W-1:0];
                        end
                        else
                            first_error_next = ST_FORMAT;
                    end
                end
                else if (!last_reg)
                begin
                    payload_length_next = len_inc(payload_length_reg);
                    if (phase_reg == PH_COUNT)
                    begin
                        if (b == CH_PIPE)
                        begin
                            if (count_digits_reg == '0 ||
                                count_digits_reg >= DIGITS_W'(COUNT_TEXT_LIMIT) ||
                                !count_has_digit_reg || count_bad_reg ||
                                (count_neg_reg && count_value_reg != '0))
                                first_error_next = ST_FORMAT;
                            else if (count_value_reg > token_cap)
                                first_error_next = ST_SMALL;
                            phase_next = PH_IDS;
                        end
                        else
                        begin
                            if ((b == CH_PLUS || b == CH_MINUS) && count_digits_reg == '0)
                                count_neg_next = (b == CH_MINUS);
                            else if (is_digit && !count_bad_reg)
                            begin
                                cv_wide = ({4'd0, count_value_reg} << 3)
                                        + ({4'd0, count_value_reg} << 1) + {11'd0, d};
                                count_value_next = (cv_wide > 15'h07FF) ? 11'h7FF
                                                   : cv_wide[TOKEN_CAP_W-1:0];
                                count_has_digit_next = 1'b1;
                            end
                            else
                                count_bad_next = 1'b1;
                            if (count_digits_reg < DIGITS_W'(COUNT_TEXT_LIMIT))
                                count_digits_next = count_digits_reg + 1'b1;
                        end
                    end
                    else if (first_error_reg == ST_OK)
                    begin
                        if (is_digit)
                        begin
                            id_lim  = id_negative_reg ? 36'h080000000 : 36'h07FFFFFFF;
                            id_wide = ({4'd0, id_acc_reg} << 3) + ({4'd0, id_acc_reg} << 1)
                                    + {32'd0, d};
                            if (id_wide > id_lim)
                                first_error_next = ST_FORMAT;
                            else
                            begin
                                id_acc_next       = id_wide[31:0];
                                id_has_digit_next = 1'b1;
                                id_started_next   = 1'b1;
                            end
                        end
                        else if ((b == CH_PLUS || b == CH_MINUS) && !id_started_reg)
                        begin
                            id_started_next  = 1'b1;
                            id_negative_next = (b == CH_MINUS);
                        end
                        else if (b == CH_COMMA && id_has_digit_reg &&
                                 ids_plus < {1'b0, count_value_reg})
                        begin
                            push.slot[n] = make_result(KIND_TOKEN,
                                id_negative_reg ? 32'd0 - id_acc_reg : id_acc_reg,
                                ST_OK, 1'b0, '0);
                            n = n + 1'b1;
                            ids_done_next     = ids_plus[TOKEN_CAP_W-1:0];
                            id_acc_next       = '0;
                            id_negative_next  = 1'b0;
                            id_has_digit_next = 1'b0;
                            id_started_next   = 1'b0;
                        end
                        else
                            first_error_next = ST_FORMAT;
                    end
                end
            end
            PH_SKIP:
            begin
            end
            default:
            begin
            end
        endcase

        if (last_reg)
        begin
            len_plus = {1'b0, payload_length_next} + 1'b1;
            if (phase_next == PH_PREFIX || phase_next == PH_SKIP)
                st = ST_FORMAT;
            else if (phase_next == PH_RAW)
                st = (len_plus > {1'b0, raw_cap}) ? ST_SMALL : ST_OK;
            else
            begin
                mode  = 1'b1;
                total = ids_done_next;
                if (!tail_nl)
                    st = ST_FORMAT;
                else if (len_plus > {1'b0, raw_cap})
                    st = ST_SMALL;
                else
                    st = first_error_next;
            end
            push.slot[n] = make_result(KIND_END, 32'd0, st, mode, total);
            n = n + 1'b1;

            phase_next           = PH_PREFIX;
            prefix_pos_next      = '0;
            prefix_kind_next     = 1'b0;
            newline_held_next    = 1'b0;
            payload_length_next  = '0;
            count_value_next     = '0;
            count_digits_next    = '0;
            count_neg_next       = 1'b0;
            count_has_digit_next = 1'b0;
            count_bad_next       = 1'b0;
            id_acc_next          = '0;
            id_negative_next     = 1'b0;
            id_has_digit_next    = 1'b0;
            id_started_next      = 1'b0;
            ids_done_next        = '0;
            first_error_next     = ST_OK;
        end

        if (n != 2'd0)
            push.slot[n - 1'b1].run_last = 1'b1;
        push.count = fire ? n : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            phase_reg           <= PH_PREFIX;
            prefix_pos_reg      <= '0;
            prefix_kind_reg     <= 1'b0;
            newline_held_reg    <= 1'b0;
            payload_length_reg  <= '0;
            count_value_reg     <= '0;
            count_digits_reg    <= '0;
            count_neg_reg       <= 1'b0;
            count_has_digit_reg <= 1'b0;
            count_bad_reg       <= 1'b0;
            id_acc_reg          <= '0;
            id_negative_reg     <= 1'b0;
            id_has_digit_reg    <= 1'b0;
            id_started_reg      <= 1'b0;
            ids_done_reg        <= '0;
            first_error_reg     <= ST_OK;
        end
        else
        begin
            if (frame.ready)
                in_valid_reg <= frame.valid;
            if (fire)
            begin
                phase_reg           <= phase_next;
                prefix_pos_reg      <= prefix_pos_next;
                prefix_kind_reg     <= prefix_kind_next;
                newline_held_reg    <= newline_held_next;
                payload_length_reg  <= payload_length_next;
                count_value_reg     <= count_value_next;
                count_digits_reg    <= count_digits_next;
                count_neg_reg       <= count_neg_next;
                count_has_digit_reg <= count_has_digit_next;
                count_bad_reg       <= count_bad_next;
                id_acc_reg          <= id_acc_next;
                id_negative_reg     <= id_negative_next;
                id_has_digit_reg    <= id_has_digit_next;
                id_started_reg      <= id_started_next;
                ids_done_reg        <= ids_done_next;
                first_error_reg     <= first_error_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            byte_reg <= frame.data_byte;
            last_reg <= frame.last_byte;
        end
    end

endmodule

// File: rtl/tfd_result_fifo.sv
module tfd_result_fifo
    import tfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tfd_push_t  push,
    output logic       space_ok,
    tfd_out_if.source  result
);

    tfd_result_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;
    logic                 pop;
    tfd_result_t          head;

    assign head     = mem[rd_ptr_reg];
    assign pop      = result.valid && result.ready;
    assign space_ok = ((FIFO_AW+1)'(FIFO_DEPTH) - cnt_reg) >= (FIFO_AW+1)'(MAX_RESULTS);

    assign result.valid       = (cnt_reg != '0);
    assign result.kind        = head.kind;
    assign result.value       = head.value;
    assign result.status      = head.status;
    assign result.frame_mode  = head.frame_mode;
    assign result.token_total = head.token_total;
    assign result.run_last    = head.run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            cnt_reg    <= cnt_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push.count)
                mem[wr_ptr_reg + FIFO_AW'(k)] <= push.slot[k];
        end
    end

endmodule

// File: rtl/text_frame_decoder_core.sv
// channel  dir  payload                                           handshake
// frame    in   data_byte, last_byte                              valid/ready
// result   out  kind, value, status, frame_mode, token_total,     valid/ready
//               run_last
// cfg      in   cfg_index, cfg_data                               cfg_we, no wait
//
// One byte is accepted per cycle while the result queue has room.
// A byte gives up to three results and the four-entry result queue drains one
// per cycle while ready is high, so bytes that give more than one result
// hold the input back; a byte is decoded only with room for three results.
// Reset clears the frame state and queue; capacities return to 256 and 64.
module text_frame_decoder_core
    import tfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tfd_in_if.sink                frame,
    tfd_out_if.source             result,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RAW_CAP_W-1:0]   raw_capacity_reg;
    logic [TOKEN_CAP_W-1:0] token_capacity_reg;
    logic [RAW_CAP_W-1:0]   raw_cap;
    logic [TOKEN_CAP_W-1:0] token_cap;
    logic                   space_ok;
    tfd_push_t              push;

    assign raw_cap   = (raw_capacity_reg < RAW_CAP_W'(MAX_RAW_BYTES))
                       ? raw_capacity_reg : RAW_CAP_W'(MAX_RAW_BYTES);
    assign token_cap = (token_capacity_reg < TOKEN_CAP_W'(MAX_TOKENS))
                       ? token_capacity_reg : TOKEN_CAP_W'(MAX_TOKENS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_capacity_reg   <= RAW_CAP_RESET;
            token_capacity_reg <= TOKEN_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RAW_CAP:   raw_capacity_reg   <= cfg_data[RAW_CAP_W-1:0];
                CFG_TOKEN_CAP: token_capacity_reg <= cfg_data[TOKEN_CAP_W-1:0];
                default:       raw_capacity_reg   <= raw_capacity_reg;
            endcase
        end
    end

    tfd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .raw_cap   (raw_cap),
        .token_cap (token_cap),
        .space_ok  (space_ok),
        .push      (push)
    );

    tfd_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .result   (result)
    );

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfd_pkg::*;

    localparam int unsigned SATURATION     = 32'h100000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 300;

    typedef enum logic [2:0] {PH_PREFIX, PH_RAW, PH_COUNT, PH_IDS, PH_SKIP} phase_t;
    typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_pattern_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } frame_item_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tfd_in_if  frame_ch ();
    tfd_out_if result_ch ();

    text_frame_decoder_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // decoder state mirrored for prediction
    string                raw_tag = "RAW|";
    string                tok_tag = "TOK|";
    logic [RAW_CAP_W-1:0] raw_cap_reg;
    logic [TOKEN_CAP_W-1:0] tok_cap_reg;
    phase_t               ph;
    int unsigned          pfx_pos;
    logic                 pfx_tok;
    logic                 nl_held;
    int unsigned          body_len;
    int unsigned          cnt_val;
    int unsigned          cnt_len;
    logic                 cnt_neg;
    logic                 cnt_digit;
    logic                 cnt_bad;
    longint unsigned      id_acc;
    logic                 id_neg;
    logic                 id_digit;
    logic                 id_started;
    int unsigned          ids_done;
    logic [1:0]           first_err;

    tfd_result_t expected_results[$];
    tfd_result_t step_out[$];
    tfd_result_t exp_r;

    frame_item_t pending_items[$];
    logic [7:0]  fbuf[$];

    logic        in_fire = 1'b0;
    logic        steady_send = 1'b0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    rx_pattern_t rx_pattern = RX_FREE;
    int          rx_pattern_left = 0;
    logic        rx_ready;
    logic        next_valid;
    frame_item_t next_item;
    int          quiet_cycles = 0;
    int          errors = 0;

    function automatic void clear_frame_state();
        ph = PH_PREFIX;
        pfx_pos = 0;
        pfx_tok = 1'b0;
        nl_held = 1'b0;
        body_len = 0;
        cnt_val = 0;
        cnt_len = 0;
        cnt_neg = 1'b0;
        cnt_digit = 1'b0;
        cnt_bad = 1'b0;
        id_acc = 0;
        id_neg = 1'b0;
        id_digit = 1'b0;
        id_started = 1'b0;
        ids_done = 0;
        first_err = ST_OK;
    endfunction

    function automatic void push_result(logic [1:0] k, logic [31:0] v, logic [1:0] st,
                                        logic m, logic [TOKEN_CAP_W-1:0] tot);
        tfd_result_t r;
        r.kind = k;
        r.value = v;
        r.status = st;
        r.frame_mode = m;
        r.token_total = tot;
        r.run_last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void note_err(logic [1:0] e);
        if (first_err == ST_OK)
            first_err = e;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic int unsigned tok_cap_eff();
        return tok_cap_reg < MAX_TOKENS ? tok_cap_reg : MAX_TOKENS;
    endfunction

    function automatic void emit_id();
        logic [31:0] mag;
        mag = id_acc[31:0];
        push_result(KIND_TOKEN, id_neg ? -mag : mag, ST_OK, 1'b0, '0);
        ids_done++;
        id_acc = 0;
        id_neg = 1'b0;
        id_digit = 1'b0;
        id_started = 1'b0;
    endfunction

    function automatic void raw_out(logic [7:0] b);
        push_result(KIND_RAW, {24'd0, b}, ST_OK, 1'b0, '0);
        if (body_len < SATURATION)
            body_len++;
    endfunction

    function automatic void count_byte(logic [7:0] b);
        if (b == CH_PIPE)
        begin
            if (cnt_len == 0 || cnt_len >= COUNT_TEXT_LIMIT || !cnt_digit || cnt_bad ||
                (cnt_neg && cnt_val != 0))
                note_err(ST_FORMAT);
            else if (cnt_val > tok_cap_eff())
                note_err(ST_SMALL);
            ph = PH_IDS;
            return;
        end
        if ((b == CH_PLUS || b == CH_MINUS) && cnt_len == 0)
            cnt_neg = (b == CH_MINUS);
        else if (is_digit(b) && !cnt_bad)
        begin
            cnt_val = cnt_val * 10 + (b - CH_ZERO);
            if (cnt_val > SATURATION)
                cnt_val = SATURATION;
            cnt_digit = 1'b1;
        end
        else
            cnt_bad = 1'b1;
        if (cnt_len < SATURATION)
            cnt_len++;
    endfunction

    function automatic void id_byte(logic [7:0] b);
        longint unsigned lim;
        longint unsigned v;
        if (first_err != ST_OK)
            return;
        if (is_digit(b))
        begin
            lim = id_neg ? 64'd2147483648 : 64'd2147483647;
            v = id_acc * 10 + (b - CH_ZERO);
            if (v > lim)
            begin
                note_err(ST_FORMAT);
                return;
            end
            id_acc = v;
            id_digit = 1'b1;
            id_started = 1'b1;
        end
        else if ((b == CH_PLUS || b == CH_MINUS) && !id_started)
        begin
            id_started = 1'b1;
            id_neg = (b == CH_MINUS);
        end
        else if (b == CH_COMMA && id_digit && ids_done + 1 < cnt_val)
            emit_id();
        else
            note_err(ST_FORMAT);
    endfunction

    function automatic void finish_ids();
        if (ph == PH_COUNT)
        begin
            note_err(ST_FORMAT);
            return;
        end
        if (first_err != ST_OK)
            return;
        if (cnt_val == 0)
        begin
            if (id_started)
                note_err(ST_FORMAT);
        end
        else if (id_digit && ids_done + 1 == cnt_val)
            emit_id();
        else
            note_err(ST_FORMAT);
    endfunction

    // expected results of one accepted byte
    function automatic void decode_byte(logic [7:0] b, logic is_last);
        logic                   tail_nl;
        logic [1:0]             st;
        logic                   mode;
        logic [TOKEN_CAP_W-1:0] total;
        int unsigned            raw_lim;
        string                  tag;
        tail_nl = 1'b0;
        step_out.delete();
        raw_lim = raw_cap_reg < MAX_RAW_BYTES ? raw_cap_reg : MAX_RAW_BYTES;
        case (ph)
            PH_PREFIX:
            begin
                if (pfx_pos == 0)
                begin
                    if (b == raw_tag[0])
                        pfx_tok = 1'b0;
                    else if (b == tok_tag[0])
                        pfx_tok = 1'b1;
                    else
                        ph = PH_SKIP;
                end
                else
                begin
                    tag = pfx_tok ? tok_tag : raw_tag;
                    if (b != tag[pfx_pos])
                        ph = PH_SKIP;
                end
                if (ph == PH_PREFIX)
                begin
                    pfx_pos++;
                    if (pfx_pos == 4)
                        ph = pfx_tok ? PH_COUNT : PH_RAW;
                end
            end
            PH_RAW:
            begin
                if (nl_held)
                begin
                    raw_out(CH_NEWLINE);
                    nl_held = 1'b0;
                end
                if (b == CH_NEWLINE)
                begin
                    if (!is_last)
                        nl_held = 1'b1;
                end
                else
                    raw_out(b);
            end
            PH_COUNT, PH_IDS:
            begin
                if (is_last && b == CH_NEWLINE)
                begin
                    tail_nl = 1'b1;
                    finish_ids();
                end
                else if (!is_last)
                begin
                    if (body_len < SATURATION)
                        body_len++;
                    if (ph == PH_COUNT)
                        count_byte(b);
                    else
                        id_byte(b);
                end
            end
            default:
            begin
            end
        endcase
        if (is_last)
        begin
            mode = 1'b0;
            total = '0;
            if (ph == PH_PREFIX || ph == PH_SKIP)
                st = ST_FORMAT;
            else if (ph == PH_RAW)
                st = (body_len + 1 > raw_lim) ? ST_SMALL : ST_OK;
            else
            begin
                mode = 1'b1;
                total = ids_done[TOKEN_CAP_W-1:0];
                if (!tail_nl)
                    st = ST_FORMAT;
                else if (body_len + 1 > raw_lim)
                    st = ST_SMALL;
                else
                    st = first_err;
            end
            push_result(KIND_END, '0, st, mode, total);
            clear_frame_state();
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].run_last = 1'b1;
        foreach (step_out[i])
            expected_results.push_back(step_out[i]);
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] exp_v,
                                          logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // frame building
    function automatic void add_text(string s);
        foreach (s[i])
            fbuf.push_back(s[i]);
    endfunction

    function automatic int send_frame();
        int n;
        frame_item_t it;
        n = fbuf.size();
        foreach (fbuf[i])
        begin
            it.data = fbuf[i];
            it.is_last = (i == n - 1);
            pending_items.push_back(it);
        end
        fbuf.delete();
        return n;
    endfunction

    function automatic void send_raw_fill(int n);
        add_text("RAW|");
        repeat (n - 1)
            fbuf.push_back(8'($urandom_range(0, 255)));
        add_text("x");
        void'(send_frame());
    endfunction

    function automatic string random_id_text();
        int v;
        v = $urandom();
        case ($urandom_range(0, 23))
            0: return "2147483647";
            1: return "-2147483648";
            2: return "2147483648";
            3: return "-2147483649";
            4: return $sformatf("+%0d", $urandom_range(0, 99));
            5: return "007";
            6, 7, 8, 9: return $sformatf("%0d", v);
            10, 11, 12: return $sformatf("-%0d", $urandom_range(0, 999));
            default: return $sformatf("%0d", $urandom_range(0, 999));
        endcase
    endfunction

    function automatic int queue_random_frame();
        int    sel;
        int    n;
        int    cnt;
        int    k;
        int    pos;
        string tag;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tok_cap_eff() + 1)
                                            : $urandom_range(0, 4);
            cnt = n;
            k = $urandom_range(0, 11);
            if (k == 0)
                cnt = n + 1;
            else if (k == 1 && n > 0)
                cnt = n - 1;
            add_text("TOK|");
            case ($urandom_range(0, 9))
                0: add_text($sformatf("+%0d", cnt));
                1: add_text(cnt == 0 ? "-0" : $sformatf("-%0d", cnt));
                2: add_text($sformatf("00%0d", cnt));
                default: add_text($sformatf("%0d", cnt));
            endcase
            add_text("|");
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_text(",");
                add_text(random_id_text());
            end
            if ($urandom_range(0, 9) != 0)
                add_text("\n");
            if ($urandom_range(0, 7) == 0 && fbuf.size() > 5)
            begin
                pos = $urandom_range(4, fbuf.size() - 1);
                fbuf[pos] = $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(0, 255));
            end
        end
        else if (sel < 80)
        begin
            add_text("RAW|");
            n = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 60 : 12);
            repeat (n)
                fbuf.push_back(($urandom_range(0, 5) == 0) ? CH_NEWLINE
                                                           : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                fbuf.push_back(CH_NEWLINE);
        end
        else if (sel < 92)
        begin
            tag = $urandom_range(0, 1) ? raw_tag : tok_tag;
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++)
                fbuf.push_back(tag[i]);
            repeat ($urandom_range(0, 4))
                fbuf.push_back(8'($urandom_range(0, 255)));
            if (fbuf.size() == 0)
                fbuf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                fbuf.push_back(8'($urandom_range(0, 255)));
        end
        return send_frame();
    endfunction

    task automatic write_cfg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RAW_CAP)
            raw_cap_reg = data;
        else
            tok_cap_reg = data[TOKEN_CAP_W-1:0];
    endtask

    task automatic set_caps(logic [CFG_DATA_W-1:0] raw_cap, logic [CFG_DATA_W-1:0] tok_cap);
        wait_idle();
        write_cfg(CFG_RAW_CAP, raw_cap);
        write_cfg(CFG_TOKEN_CAP, tok_cap);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || frame_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // sender: bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            frame_ch.valid <= 1'b0;
        else if (!frame_ch.valid || in_fire)
        begin
            next_valid = 1'b0;
            if (gap_left > 0 && !steady_send)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                             : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            frame_ch.valid <= next_valid;
            if (next_valid)
            begin
                frame_ch.data_byte <= next_item.data;
                frame_ch.last_byte <= next_item.is_last;
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (rx_pattern_left == 0)
        begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_pattern_left = $urandom_range(16, 96);
        end
        else
            rx_pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            rx_ready = 1'b0;
        end
        else
        begin
            case (rx_pattern)
                RX_FREE:   rx_ready = 1'b1;
                RX_HALF:   rx_ready = $urandom_range(0, 1);
                RX_MOSTLY: rx_ready = $urandom_range(0, 3) != 0;
                default:   rx_ready = $urandom_range(0, 3) == 0;
            endcase
        end
        result_ch.ready <= rx_ready;
    end

    always @(posedge clk)
    begin
        in_fire = rst_n && frame_ch.valid && frame_ch.ready;
        if (in_fire)
            decode_byte(frame_ch.data_byte, frame_ch.last_byte);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d status %0d",
                       result_ch.kind, result_ch.value, result_ch.status);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                compare_field("kind", exp_r.kind, result_ch.kind);
                compare_field("value", exp_r.value, result_ch.value);
                compare_field("status", exp_r.status, result_ch.status);
                compare_field("frame_mode", exp_r.frame_mode, result_ch.frame_mode);
                compare_field("token_total", exp_r.token_total, result_ch.token_total);
                compare_field("run_last", exp_r.run_last, result_ch.run_last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_frame_decoder_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int queued;
        frame_ch.valid = 1'b0;
        frame_ch.data_byte = '0;
        frame_ch.last_byte = 1'b0;
        result_ch.ready = 1'b0;
        raw_cap_reg = RAW_CAP_RESET;
        tok_cap_reg = TOKEN_CAP_RESET;
        clear_frame_state();
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset capacities
        add_text("RAW|");
        fbuf.push_back(8'h00);
        fbuf.push_back(8'hFF);
        add_text("\n");
        void'(send_frame());
        add_text("RAW|a\n\nb");
        void'(send_frame());
        add_text("RAW|");
        void'(send_frame());
        add_text("X");
        void'(send_frame());
        add_text("TO");
        void'(send_frame());
        add_text("TOK|");
        void'(send_frame());
        add_text("TOK|3|-2147483648,+0,2147483647\n");
        void'(send_frame());
        add_text("TOK|-0|\n");
        void'(send_frame());
        add_text("TOK|2|1, 2\n");
        void'(send_frame());
        add_text("TOK|1|2147483648\n");
        void'(send_frame());
        add_text("TOK|65|\n");
        void'(send_frame());
        add_text("TOK|99999999999|\n");
        void'(send_frame());
        add_text("TOK|");
        repeat (30)
            fbuf.push_back(CH_ZERO);
        add_text("2|1,2\n");
        void'(send_frame());
        add_text("TOK|");
        repeat (31)
            fbuf.push_back(CH_ZERO);
        add_text("2|1,2\n");
        void'(send_frame());
        add_text("TOK|2|1\n2\n");
        void'(send_frame());
        add_text("TOK|1|");
        fbuf.push_back(8'h00);
        add_text("\n");
        void'(send_frame());
        add_text("TOK|+1|5");
        void'(send_frame());
        add_text("TOK|1|-\n");
        void'(send_frame());

        // zero capacities
        set_caps(13'd0, 13'd0);
        add_text("RAW|");
        void'(send_frame());
        add_text("TOK|0|\n");
        void'(send_frame());

        set_caps(13'd1, 13'd1);
        add_text("RAW|");
        void'(send_frame());
        add_text("RAW|z");
        void'(send_frame());
        add_text("TOK|1|5\n");
        void'(send_frame());

        // top of range, and above it
        set_caps(13'd4096, 13'd1024);
        send_raw_fill(16);
        add_text("TOK|1024|7\n");
        void'(send_frame());
        add_text("TOK|1025|\n");
        void'(send_frame());

        set_caps(13'h1FFF, 13'h1FFF);
        send_raw_fill(16);
        add_text("TOK|1025|\n");
        void'(send_frame());

        for (int p = 0; p < 6; p++)
        begin
            set_caps(13'($urandom_range(4, 48)),
                     {2'($urandom()), 11'($urandom_range(0, 6))});
            steady_send = 1'b0;
            if (p == 2)
            begin
                steady_send = 1'b1;
                hold_req = 1'b1;
            end
            queued = 0;
            while (queued < 18)
                queued += queue_random_frame();
        end

        wait_idle();
        if (errors == 0)
            $display("text_frame_decoder_core: match");
        else
            $display("text_frame_decoder_core: mismatch");
        $finish;
    end

endmodule
